[hw/rtl/isqb_pkg.sv]
package isqb_pkg;

  // Port widths of the radicand and root words
  localparam int RAD_W  = 64;
  localparam int ROOT_W = 32;

  // Datapath width of the radicand; upper bits of the input word are ignored
  localparam int WIDTH = 64;

  // Root bits resolved by the chain (one per cell) and padded radicand width
  localparam int RW = (WIDTH + 1) / 2;
  localparam int PW = 2 * RW;

  // Saturation value of the root: 2^(WIDTH/2) - 1
  localparam logic [RW-1:0] ROOT_TOP = RW'((64'd1 << (WIDTH / 2)) - 64'd1);

  // Data handed from one cell to the next
  typedef struct packed {
    logic [PW-1:0]   rad;   // radicand bits not yet consumed, MSB first
    logic [RW+1:0]   rem;   // running remainder
    logic [RW-1:0]   root;  // root bits resolved so far
  } isqb_cell_t;

endpackage

[hw/rtl/isqb_in_if.sv]
interface isqb_in_if;
  import isqb_pkg::*;

  logic             valid;
  logic             ready;
  logic [RAD_W-1:0] radicand;

  modport source (output valid, output radicand, input ready);
  modport sink   (input valid, input radicand, output ready);
endinterface

[hw/rtl/isqb_out_if.sv]
interface isqb_out_if;
  import isqb_pkg::*;

  logic              valid;
  logic              ready;
  logic [ROOT_W-1:0] root;

  modport source (output valid, output root, input ready);
  modport sink   (input valid, input root, output ready);
endinterface

[hw/rtl/isqb_cell.sv]
module isqb_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                prev_valid,
  input  isqb_pkg::isqb_cell_t prev_data,
  output logic                valid,
  output isqb_pkg::isqb_cell_t data
);
  import isqb_pkg::*;

  logic          valid_r;
  isqb_cell_t    data_r;
  isqb_cell_t    data_nxt;
  logic [RW+1:0] rem_sh;
  logic [RW+1:0] trial;
  logic          take;

  // Resolve one root bit: bring down two radicand bits, try 4*root+1
  always_comb begin
    rem_sh = {prev_data.rem[RW-1:0], prev_data.rad[PW-1:PW-2]};
    trial  = {prev_data.root, 2'b01};
    take   = (rem_sh >= trial);
    data_nxt.rad  = {prev_data.rad[PW-3:0], 2'b00};
    data_nxt.rem  = take ? (rem_sh - trial) : rem_sh;
    data_nxt.root = {prev_data.root[RW-2:0], take};
  end

  // Advance with the whole chain, hold on stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign valid = valid_r;
  assign data  = data_r;

  // Remainder never exceeds twice the partial root
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (data_r.rem <= (RW+2)'({data_r.root, 1'b0})))
    else $error("cell remainder above twice the partial root");

endmodule

[hw/rtl/integer_square_root_bisection_core.sv]
// Channel  Dir  Payload              Handshake
// in_ch    in   radicand [63:0]      valid/ready, taken when both high
// out_ch   out  root     [31:0]      valid/ready, taken when both high
//
// A word passes through the 32-cell chain, one root bit per cell, and then
// the output register. A new word can enter every cycle while the chain moves.
// The chain and the output register stall together while a result waits
// and out_ch.ready is low; in_ch.ready is low for that time.
// Reset (rst_n low, synchronous) clears all valid bits; data is not reset.
module integer_square_root_bisection_core (
  input  logic              clk,
  input  logic              rst_n,
  isqb_in_if.sink           in_ch,
  isqb_out_if.source        out_ch
);
  import isqb_pkg::*;

  logic                adv;
  logic [RW:0]         vld;
  isqb_cell_t          dat [RW+1];
  logic [RW-1:0]       root_sat;
  logic                out_valid_r;
  logic [ROOT_W-1:0]   out_root_r;

  // Move the chain whenever the output register is free or being drained
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // Feed the first cell: masked radicand, zero remainder and root
  assign vld[0]      = in_ch.valid;
  assign dat[0].rad  = PW'(in_ch.radicand[WIDTH-1:0]);
  assign dat[0].rem  = '0;
  assign dat[0].root = '0;

  // Row of cells, one root bit each, MSB first
  for (genvar g = 0; g < RW; g++) begin : g_cell
    isqb_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .adv        (adv),
      .prev_valid (vld[g]),
      .prev_data  (dat[g]),
      .valid      (vld[g+1]),
      .data       (dat[g+1])
    );
  end

  // Clamp to the saturation value
  assign root_sat = (dat[RW].root > ROOT_TOP) ? ROOT_TOP : dat[RW].root;

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_root_r <= ROOT_W'(root_sat);
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.root  = out_root_r;

  // Result never exceeds the saturation value
  a_root_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_root_r <= ROOT_W'(ROOT_TOP)))
    else $error("root above saturation value");

  // A finished word at the chain end lands in the output register
  a_land: assert property (@(posedge clk) disable iff (!rst_n)
    (vld[RW] && adv) |=> out_valid_r)
    else $error("finished word lost at chain end");

  // A stall freezes the occupancy of the whole chain
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld[RW:1]))
    else $error("chain moved during stall");

endmodule

[tb/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import isqb_pkg::*;

  localparam int HALF        = WIDTH / 2;
  localparam int RANDOM_N    = 1830;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 40;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [ROOT_W-1:0] SAT_ROOT = ROOT_W'((128'd1 << HALF) - 128'd1);

  // One row of the directed table; typed rows carry their root, the rest use the predictor
  typedef struct {
    logic [RAD_W-1:0]  radicand;
    bit                typed;
    logic [ROOT_W-1:0] root;
  } dir_row_t;

  localparam int DIR_N = 20;
  dir_row_t directed_rows [DIR_N] = '{
    '{64'h0000_0000_0000_0000, 1'b1, 32'h0000_0000},
    '{64'h0000_0000_0000_0001, 1'b1, 32'h0000_0001},
    '{64'h0000_0000_0000_0002, 1'b1, 32'h0000_0001},
    '{64'h0000_0000_0000_0003, 1'b1, 32'h0000_0001},
    '{64'h0000_0000_0000_0004, 1'b1, 32'h0000_0002},
    '{64'h0000_0000_0000_0008, 1'b1, 32'h0000_0002},
    '{64'h0000_0000_0000_0009, 1'b1, 32'h0000_0003},
    '{64'h0000_0000_0000_000F, 1'b1, 32'h0000_0003},
    '{64'h0000_0000_0000_0010, 1'b1, 32'h0000_0004},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
    '{64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 32'hFFFF_FFFF},
    '{64'hFFFF_FFFE_0000_0001, 1'b1, 32'hFFFF_FFFF},
    '{64'hFFFF_FFFE_0000_0000, 1'b1, 32'hFFFF_FFFE},
    '{64'h0000_0001_0000_0000, 1'b1, 32'h0001_0000},
    '{64'h4000_0000_0000_0000, 1'b1, 32'h8000_0000},
    '{64'h0000_0000_FFFF_FFFF, 1'b0, 32'h0},
    '{64'h8000_0000_0000_0000, 1'b0, 32'h0},
    '{64'h3FFF_FFFF_FFFF_FFFF, 1'b0, 32'h0},
    '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 32'h0},
    '{64'h5555_5555_5555_5555, 1'b0, 32'h0}
  };

  logic clk = 1'b0;
  logic rst_n;

  isqb_in_if  in_ch ();
  isqb_out_if out_ch ();

  integer_square_root_bisection_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  logic [ROOT_W-1:0] pending_roots [$];
  int  mismatches = 0;
  int  words_sent = 0;
  int  roots_seen = 0;
  int  sat_count  = 0;
  int  cycles     = 0;
  bit  rx_hold    = 1'b0;
  int  held_cycles = 0;

  // Floor square root of the radicand at WIDTH bits, saturated at the top root
  function automatic logic [ROOT_W-1:0] floor_root(input logic [RAD_W-1:0] word);
    logic [127:0] n, top, lo, hi, mid;
    n   = {64'd0, word} & ((128'd1 << WIDTH) - 128'd1);
    top = (128'd1 << HALF) - 128'd1;
    if (n < 128'd2) return n[ROOT_W-1:0];
    if (n >= top * top) return top[ROOT_W-1:0];
    lo = 128'd1;
    hi = (n < top) ? n : top;
    // narrow the bounds until they touch
    while (lo + 128'd1 < hi) begin
      mid = lo + (hi - lo) / 128'd2;
      if (mid * mid > n) hi = mid;
      else lo = mid;
    end
    return lo[ROOT_W-1:0];
  endfunction

  // Random radicand, weighted toward squares, their neighbors and the saturation edge
  function automatic logic [RAD_W-1:0] pick_radicand();
    logic [RAD_W-1:0] k;
    int kind;
    kind = $urandom_range(0, 9);
    k = {32'd0, $urandom()};
    case (kind)
      0, 1, 2: return {$urandom(), $urandom()};
      3, 4:    return {$urandom(), $urandom()} >> $urandom_range(0, 63);
      5, 6:    return k * k + 64'($signed($urandom_range(0, 2)) - 1);
      7:       return 64'hFFFF_FFFE_0000_0001 + 64'($signed($urandom_range(0, 6)) - 3);
      8:       return 64'($urandom_range(0, 20));
      default: begin
        k = k >> $urandom_range(0, 31);
        return k * k - 64'd1;
      end
    endcase
  endfunction

  task automatic report(input string what, input logic [ROOT_W-1:0] got,
                        input logic [ROOT_W-1:0] want);
    $display("[%0t] MISMATCH %s: root got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Offer one word, after a random gap outside the calm window; hold it until taken, then queue its root
  task automatic send_word(input logic [RAD_W-1:0] word, input logic [ROOT_W-1:0] root);
    bit calm;
    calm = (words_sent >= 900) && (words_sent < 1200);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 38) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.radicand <= word;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_roots.push_back(root);
    words_sent++;
    if (root == SAT_ROOT) sat_count++;
  endtask

  // Drive the result-side ready: low in reset, random stalls, a calm window, and the long hold
  always @(negedge clk) begin
    if (!rst_n || rx_hold) begin
      out_ch.ready <= 1'b0;
    end else if (roots_seen >= 900 && roots_seen < 1200) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= 38);
    end
  end

  // Hold off the result side for a long stretch so the chain fills and stalls its input
  initial begin
    wait (roots_seen >= 400);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) begin
      @(posedge clk);
      held_cycles++;
    end
    rx_hold = 1'b0;
  end

  // Check each accepted root against the oldest expectation
  always @(posedge clk) begin
    logic [ROOT_W-1:0] want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_roots.size() == 0) begin
        report("unexpected word", out_ch.root, 'x);
      end else begin
        want = pending_roots.pop_front();
        if (out_ch.root !== want) report("root", out_ch.root, want);
      end
      roots_seen++;
    end
  end

  // Drop the run if it stops making progress
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d roots still due", cycles, pending_roots.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [RAD_W-1:0] word;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.radicand = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].radicand,
                directed_rows[i].typed ? directed_rows[i].root
                                       : floor_root(directed_rows[i].radicand));
    end

    // Random radicands, checked against the predictor
    repeat (RANDOM_N) begin
      word = pick_radicand();
      send_word(word, floor_root(word));
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;

    // Drain the chain, then give stray words a chance to show up
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("sent %0d radicands (%0d from the table), checked %0d roots, %0d saturated",
             words_sent, DIR_N, roots_seen, sat_count);
    $display("result side held off for %0d cycles; %0d mismatches in %0d cycles",
             held_cycles, mismatches, cycles);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/isqb_pkg.sv
hw/rtl/isqb_in_if.sv
hw/rtl/isqb_out_if.sv
hw/rtl/isqb_cell.sv
hw/rtl/integer_square_root_bisection_core.sv
tb/testbench.sv
